// ----- rtl/ptwa_pkg.sv -----
package ptwa_pkg;

  localparam int ADDR_W    = 32;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam kind_t EV_LOST = 2'd0;
  localparam kind_t EV_DISC = 2'd1;
  localparam kind_t EV_DROP = 2'd2;

  localparam cfg_idx_t CFG_EXPIRY = 2'd0;
  localparam cfg_idx_t CFG_OWN    = 2'd1;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd8000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] heard;
  } entry_t;

  localparam int ENTRY_W = ADDR_W + TIME_W;

endpackage

// ----- rtl/peer_table_with_aging.sv -----
// Peer table with aging.
// Input channel (in_valid/in_ready): one transfer carries opcode, now_ms and
// peer_address. The block takes one item at a time; in_ready is high only
// while no item is in work.
// Output channel (out_valid/out_ready): zero or more events per item, lost
// events first (highest table position first), then at most one discovered
// or dropped event; last_event marks the final event of an item.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 sets the
// expiry limit, index 1 the own address, other indexes are ignored.
// Timing: an item walks the stored entries one per cycle when the receiver
// keeps up, through the single age compare: first an aging walk downward,
// then a compacting walk upward over the entry RAM, between the accept,
// append and flush states. An output stall holds the aging walk and append.
// Reset empties the table and resets the control and config registers; the
// entry RAM is not cleared, entries above the count are never read.
module peer_table_with_aging import ptwa_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [ADDR_W-1:0] peer_address,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             event_kind,
  output logic [ADDR_W-1:0] event_address,
  output logic              last_event
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_AGE, S_COMPACT, S_FIN, S_DRAIN} state_t;

  state_t            state;
  logic [TIME_W-1:0] expiry_limit_ms;
  logic [ADDR_W-1:0] own_address;
  logic              op_r;
  logic [TIME_W-1:0] now_r;
  logic [ADDR_W-1:0] peer_r;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     wp;
  logic [IW-1:0]     ptr;
  logic              found;
  logic              pend_v;
  kind_t             pend_kind;
  logic [ADDR_W-1:0] pend_addr;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              addr_hit;
  logic              out_free;
  logic              new_peer;
  logic              has_room;
  logic              age_stall;
  logic              fin_stall;
  logic              out_load;

  ptwa_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp[IW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign age       = now_r - rd_entry.heard;
  assign expired   = age > expiry_limit_ms;
  assign addr_hit  = rd_entry.addr == peer_r;
  assign out_free  = !out_valid || out_ready;
  assign new_peer  = op_r && !found && (peer_r != own_address);
  assign has_room  = wp < CW'(TABLE_DEPTH);
  assign age_stall = expired && pend_v && !out_free;
  assign fin_stall = new_peer && pend_v && !out_free;
  assign out_load  = ((state == S_AGE) && expired && pend_v && out_free) ||
                     ((state == S_FIN) && new_peer && pend_v && out_free) ||
                     ((state == S_DRAIN) && pend_v && out_free);

  always_comb begin
    case (state)
      S_IDLE:    rd_addr = IW'(cnt - CW'(1));
      S_AGE:     rd_addr = (age_stall || ptr == '0) ? ptr : ptr - IW'(1);
      S_COMPACT: rd_addr = ptr + IW'(1);
      default:   rd_addr = ptr;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_entry.addr  = peer_r;
    wr_entry.heard = now_r;
    case (state)
      S_COMPACT: begin
        wr_en = !expired;
        wr_entry.addr  = rd_entry.addr;
        wr_entry.heard = (op_r && addr_hit) ? now_r : rd_entry.heard;
      end
      S_FIN: begin
        wr_en = new_peer && has_room && !fin_stall;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      expiry_limit_ms <= EXPIRY_RESET;
      own_address     <= '0;
      cnt             <= '0;
      pend_v          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_EXPIRY: expiry_limit_ms <= cfg_data;
          CFG_OWN:    own_address     <= cfg_data;
          default:    ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= opcode;
            now_r  <= now_ms;
            peer_r <= peer_address;
            wp     <= '0;
            found  <= 1'b0;
            ptr    <= IW'(cnt - CW'(1));
            state  <= (cnt != '0) ? S_AGE : S_FIN;
          end
        end
        S_AGE: begin
          if (!age_stall) begin
            if (expired) begin
              if (pend_v) begin
                event_kind    <= pend_kind;
                event_address <= pend_addr;
                last_event    <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_kind <= EV_LOST;
              pend_addr <= rd_entry.addr;
            end
            if (ptr == '0) begin
              state <= S_COMPACT;
            end else begin
              ptr <= ptr - IW'(1);
            end
          end
        end
        S_COMPACT: begin
          if (!expired) begin
            wp <= wp + CW'(1);
            if (op_r && addr_hit) begin
              found <= 1'b1;
            end
          end
          if (CW'(ptr) == cnt - CW'(1)) begin
            state <= S_FIN;
          end else begin
            ptr <= ptr + IW'(1);
          end
        end
        S_FIN: begin
          if (!fin_stall) begin
            cnt <= (new_peer && has_room) ? wp + CW'(1) : wp;
            if (new_peer) begin
              if (pend_v) begin
                event_kind    <= pend_kind;
                event_address <= pend_addr;
                last_event    <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_kind <= has_room ? EV_DISC : EV_DROP;
              pend_addr <= peer_r;
            end
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            event_kind    <= pend_kind;
            event_address <= pend_addr;
            last_event    <= 1'b1;
            pend_v        <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_age_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE || state == S_COMPACT) |-> CW'(ptr) < cnt)
    else $error("walk pointer beyond stored entries");

  a_compact_wp: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT) |-> wp <= CW'(ptr))
    else $error("compaction write overtakes read");

  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("pending event left at idle");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cnt != '0) |=> (state == S_AGE))
    else $error("accepted item skipped aging walk");

endmodule

// ----- rtl/ptwa_ram.sv -----
module ptwa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
